/* rtl/core/signed_word_to_decimal_ascii_macros.svh */
// ----------------------------------------------------------------------------
// signed_word_to_decimal_ascii_macros.svh
// Assertion shorthands shared by the decimal formatter modules
// ----------------------------------------------------------------------------
`ifndef SIGNED_WORD_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_WORD_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define SW2D_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define SW2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/sw2d_pkg.sv */
// ----------------------------------------------------------------------------
// sw2d_pkg
// Shared constants and the word record carried down the digit pipeline
// ----------------------------------------------------------------------------
package sw2d_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned CHAR_W   = 6;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned NUM_DIG  = 5;
    localparam int unsigned CNT_W    = 3;

    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0]  CHAR_NINE  = 6'd57;
    localparam logic [DIGIT_W-1:0] RADIX      = 4'd10;

    // floor(x / 10) == (x * 0xCCCD) >> 19 for every 16-bit x
    localparam logic [WORD_W-1:0]  RECIP_DIV10 = 16'hCCCD;
    localparam int unsigned        RECIP_SHIFT = 19;

    typedef struct packed {
        logic                             neg;
        logic [WORD_W-1:0]                mag;
        logic [CNT_W-1:0]                 ndig;
        logic [NUM_DIG-1:0][DIGIT_W-1:0]  digit;
    } sw2d_word_t;

endpackage

/* rtl/core/sw2d_digit_stage.sv */
// ----------------------------------------------------------------------------
// sw2d_digit_stage
// One divide-by-ten step: peels the low decimal digit off the magnitude
// ----------------------------------------------------------------------------
`include "signed_word_to_decimal_ascii_macros.svh"

module sw2d_digit_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sw2d_pkg::sw2d_word_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sw2d_pkg::sw2d_word_t out_data
);
    import sw2d_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    sw2d_word_t        data_reg;
    sw2d_word_t        data_next;
    logic [2*WORD_W-1:0] prod;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] quot_x10;
    logic [WORD_W-1:0] rem_full;
    logic              advance;

    assign in_ready = !valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    assign prod     = (2*WORD_W)'(in_data.mag) * (2*WORD_W)'(RECIP_DIV10);
    assign quot     = WORD_W'(prod >> RECIP_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem_full = in_data.mag - quot_x10;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
        if (advance) begin
            data_next.neg   = in_data.neg;
            data_next.mag   = quot;
            // count stages that still see a nonzero value
            data_next.ndig  = (in_data.mag != '0) ? in_data.ndig + 1'b1 : in_data.ndig;
            data_next.digit = {rem_full[DIGIT_W-1:0], in_data.digit[NUM_DIG-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    `SW2D_ASSERT_SAME(a_digit_range, valid_reg, data_reg.digit[NUM_DIG-1] < RADIX, "digit out of range")
    `SW2D_ASSERT_SAME(a_quot_range, valid_reg, data_reg.mag <= 16'd6553, "quotient too large")
    `SW2D_ASSERT_NEXT(a_hold_stall, valid_reg && !out_ready, valid_reg && $stable(data_reg), "stalled stage changed")

endmodule

/* rtl/core/signed_word_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_word_to_decimal_ascii
// Formats a signed 16-bit word as decimal ASCII, one character per request.
// The word is registered in the sign stage, each digit stage and the serializer
//   before its first character is valid; each word gives 1 to 6 characters,
//   sent one at a time by the single-character output serializer.
// Pipeline: sign stage, five divide-by-ten stages, then the serializer.
// Reset: synchronous active-low aresetn clears all valid bits; no data reset.
// ----------------------------------------------------------------------------
`include "signed_word_to_decimal_ascii_macros.svh"

module signed_word_to_decimal_ascii (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [sw2d_pkg::WORD_W-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sw2d_pkg::CHAR_W-1:0]   m_ascii_char,
    output logic                          m_last
);
    import sw2d_pkg::*;

    // sign stage
    logic       sgn_valid_reg;
    logic       sgn_valid_next;
    sw2d_word_t sgn_data_reg;
    sw2d_word_t sgn_data_next;
    logic       sgn_out_ready;
    logic [WORD_W-1:0] raw;

    // digit pipeline links
    logic       lnk_valid [NUM_DIG+1];
    logic       lnk_ready [NUM_DIG+1];
    sw2d_word_t lnk_data  [NUM_DIG+1];

    // serializer
    logic                            ser_valid_reg;
    logic                            ser_valid_next;
    logic                            neg_pending_reg;
    logic                            neg_pending_next;
    logic [CNT_W-1:0]                pos_reg;
    logic [CNT_W-1:0]                pos_next;
    logic [NUM_DIG-1:0][DIGIT_W-1:0] digit_reg;
    logic [NUM_DIG-1:0][DIGIT_W-1:0] digit_next;
    logic                            out_fire;
    logic                            word_done;
    logic                            load;

    // sign / magnitude
    assign raw     = WORD_W'(s_value);
    assign s_ready = !sgn_valid_reg || sgn_out_ready;

    always_comb begin
        sgn_valid_next = sgn_valid_reg;
        sgn_data_next  = sgn_data_reg;
        if (s_ready) begin
            sgn_valid_next = s_valid;
        end
        if (s_valid && s_ready) begin
            sgn_data_next.neg   = raw[WORD_W-1];
            // most negative word maps to 0x8000, which is right as unsigned
            sgn_data_next.mag   = raw[WORD_W-1] ? (~raw + 1'b1) : raw;
            sgn_data_next.ndig  = '0;
            sgn_data_next.digit = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sgn_valid_reg <= 1'b0;
        end else begin
            sgn_valid_reg <= sgn_valid_next;
        end
        sgn_data_reg <= sgn_data_next;
    end

    assign lnk_valid[0] = sgn_valid_reg;
    assign lnk_data[0]  = sgn_data_reg;
    assign sgn_out_ready = lnk_ready[0];

    for (genvar g = 0; g < NUM_DIG; g++) begin : g_dig
        sw2d_digit_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (lnk_valid[g]),
            .in_ready  (lnk_ready[g]),
            .in_data   (lnk_data[g]),
            .out_valid (lnk_valid[g+1]),
            .out_ready (lnk_ready[g+1]),
            .out_data  (lnk_data[g+1])
        );
    end

    // serializer: one character per request, reloads on the last one
    assign m_valid      = ser_valid_reg;
    assign m_last       = !neg_pending_reg && (pos_reg == '0);
    assign m_ascii_char = neg_pending_reg ? CHAR_MINUS
                                          : CHAR_ZERO + CHAR_W'(digit_reg[pos_reg]);
    assign out_fire  = m_valid && m_ready;
    assign word_done = out_fire && m_last;
    assign lnk_ready[NUM_DIG] = !ser_valid_reg || word_done;
    assign load      = lnk_valid[NUM_DIG] && lnk_ready[NUM_DIG];

    always_comb begin
        ser_valid_next   = ser_valid_reg;
        neg_pending_next = neg_pending_reg;
        pos_next         = pos_reg;
        digit_next       = digit_reg;
        if (load) begin
            ser_valid_next   = 1'b1;
            neg_pending_next = lnk_data[NUM_DIG].neg;
            // zero has no nonzero stage but still prints one digit
            pos_next         = (lnk_data[NUM_DIG].ndig == '0) ? '0
                                                              : lnk_data[NUM_DIG].ndig - 1'b1;
            digit_next       = lnk_data[NUM_DIG].digit;
        end else if (word_done) begin
            ser_valid_next = 1'b0;
        end else if (out_fire) begin
            if (neg_pending_reg) begin
                neg_pending_next = 1'b0;
            end else begin
                pos_next = pos_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
        end else begin
            ser_valid_reg <= ser_valid_next;
        end
        neg_pending_reg <= neg_pending_next;
        pos_reg         <= pos_next;
        digit_reg       <= digit_next;
    end

    `SW2D_ASSERT_SAME(a_sign_not_last, m_valid && (m_ascii_char == CHAR_MINUS), !m_last, "sign flagged last")
    `SW2D_ASSERT_SAME(a_char_range, m_valid, (m_ascii_char == CHAR_MINUS) || ((m_ascii_char >= CHAR_ZERO) && (m_ascii_char <= CHAR_NINE)), "bad character")
    `SW2D_ASSERT_NEXT(a_word_continues, m_valid && m_ready && !m_last, m_valid, "word cut short")
    `SW2D_ASSERT_SAME(a_pos_range, ser_valid_reg, pos_reg < CNT_W'(NUM_DIG), "digit index out of range")

endmodule
